### sv/yzd_pkg.sv
// Shared types and constants of the Yaz0 stream decompressor.
package yzd_pkg;

    localparam int unsigned DefWindowDepth = 4096;
    localparam int unsigned DefOutLanes    = 8;

    localparam int unsigned OffW = 13;   // offset 1..4096
    localparam int unsigned LenW = 9;    // length up to 273

    localparam logic [7:0] FlagLitMask = 8'h80;
    localparam logic [7:0] NibHiMask   = 8'hF0;
    localparam logic [8:0] LongBias    = 9'h012;
    localparam logic [8:0] ShortBias   = 9'h002;

    // One decoded command from the parser to the copy engine.
    typedef struct packed {
        logic            is_lit;
        logic [7:0]      lit;
        logic [OffW-1:0] offset;
        logic [LenW-1:0] len;
        logic            last;
        logic            end_in_token;
    } t_cmd;

    localparam int unsigned CmdW = $bits(t_cmd);

endpackage

### sv/yzd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module yzd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/yzd_fifo.sv
// Small register queue used between parser and engine and at the result side.
module yzd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule

### sv/yzd_front.sv
// Token parser: tracks layout flags and reference bytes, emits literal and copy commands.
module yzd_front import yzd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [31:0] i_limit,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd
);
    logic [7:0]  r_layout, n_layout;
    logic [3:0]  r_left, n_left;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_second, n_second;
    logic [31:0] r_bw, n_bw;

    logic [31:0]     room;
    logic [LenW-1:0] raw_len, clip_len;
    logic [7:0]      hi_byte, lo_byte;
    logic            is_copy, is_lit;

    always_comb begin
        n_layout = r_layout;
        n_left   = r_left;
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        n_bw     = r_bw;
        is_copy  = 1'b0;
        is_lit   = 1'b0;
        raw_len  = '0;
        hi_byte  = r_first;
        lo_byte  = r_second;
        room     = i_limit - r_bw;

        if (i_valid && !(r_bw >= i_limit && r_phase == 2'd0)) begin
            if (r_phase == 2'd0 && r_left == 4'd0) begin
                n_layout = i_byte;
                n_left   = 4'd8;
            end else if (r_phase == 2'd0 && (r_layout & FlagLitMask) != 8'h00) begin
                is_lit = 1'b1;
            end else if (r_phase == 2'd0) begin
                n_first = i_byte;
                n_phase = 2'd1;
            end else if (r_phase == 2'd1) begin
                n_second = i_byte;
                lo_byte  = i_byte;
                if ((r_first & NibHiMask) == 8'h00) begin
                    n_phase = 2'd2;
                end else begin
                    is_copy = 1'b1;
                    raw_len = LenW'(r_first[7:4]) + ShortBias;
                end
            end else begin
                is_copy = 1'b1;
                raw_len = LenW'(i_byte) + LongBias;
            end
        end

        clip_len = (32'(raw_len) > room) ? room[LenW-1:0] : raw_len;

        if (is_lit || is_copy) begin
            n_layout = {r_layout[6:0], 1'b0};
            n_left   = (r_left != 4'd0) ? r_left - 4'd1 : r_left;
            n_phase  = 2'd0;
            n_bw     = is_lit ? r_bw + 32'd1 : r_bw + 32'(clip_len);
        end

        o_cmd.is_lit       = is_lit;
        o_cmd.lit          = i_byte;
        o_cmd.offset       = OffW'({hi_byte[3:0], lo_byte}) + OffW'(1);
        o_cmd.len          = is_lit ? LenW'(1) : (is_copy ? clip_len : '0);
        o_cmd.last         = i_last;
        o_cmd.end_in_token = i_last && (n_phase != 2'd0);
        o_cmd_valid        = i_valid && (is_lit || (is_copy && clip_len != '0) || i_last);

        // drop all stream state at the end of the stream
        if (i_valid && i_last) begin
            n_layout = '0;
            n_left   = '0;
            n_phase  = '0;
            n_first  = '0;
            n_second = '0;
            n_bw     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= '0;
            r_left   <= '0;
            r_phase  <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_bw     <= '0;
        end else begin
            r_layout <= n_layout;
            r_left   <= n_left;
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_bw     <= n_bw;
        end
    end
endmodule

### sv/yzd_back.sv
// Copy engine: writes the history window, copies references, packs result words.
module yzd_back import yzd_pkg::*; #(
    parameter int unsigned WINDOW_DEPTH = DefWindowDepth,
    parameter int unsigned OUT_LANES    = DefOutLanes
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_empty,
    input  t_cmd                           i_cmd,
    output logic                           o_cmd_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output logic [8*OUT_LANES-1:0]         o_data,
    output logic [$clog2(OUT_LANES+1)-1:0] o_count,
    output logic                           o_last,
    output logic                           o_done,
    output logic                           o_err
);
    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned CW = $clog2(OUT_LANES + 1);
    localparam int unsigned LW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WR   = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [31:0]            r_bw, n_bw;
    logic                   r_err, n_err;
    logic [LenW-1:0]        r_left, n_left;
    logic [8*OUT_LANES-1:0] r_word, n_word;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_final, n_final;

    logic [31:0] src;
    logic [7:0]  rdata, value;
    logic        ram_we;

    assign src = r_bw - 32'(r_cmd.offset);

    yzd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_bw[AW-1:0]),
        .i_wdata(value),
        .i_raddr(src[AW-1:0]),
        .o_rdata(rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_bw      = r_bw;
        n_err     = r_err;
        n_left    = r_left;
        n_word    = r_word;
        n_cnt     = r_cnt;
        n_final   = r_final;
        o_cmd_pop = 1'b0;
        o_res_push = 1'b0;
        ram_we    = 1'b0;
        value     = r_cmd.is_lit ? r_cmd.lit
                  : ((r_bw < 32'(r_cmd.offset)) ? 8'h00 : rdata);

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_left    = i_cmd.len;
                    // a copy whose source lies before the stream start raises the error flag
                    if (!i_cmd.is_lit && i_cmd.len != '0 && r_bw < 32'(i_cmd.offset)) begin
                        n_err = 1'b1;
                    end
                    if (i_cmd.len == '0) begin
                        n_final = 1'b1;
                        n_state = S_PUSH;
                    end else if (i_cmd.is_lit) begin
                        n_state = S_WR;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                ram_we = 1'b1;
                n_bw   = r_bw + 32'd1;
                n_word[8*r_cnt[LW-1:0] +: 8] = value;
                n_cnt  = r_cnt + CW'(1);
                n_left = r_left - LenW'(1);
                if (r_left == LenW'(1) || r_cnt == CW'(OUT_LANES - 1)) begin
                    n_final = (r_left == LenW'(1));
                    n_state = S_PUSH;
                end else begin
                    n_state = S_RD;
                end
            end
            S_PUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_word     = '0;
                    n_cnt      = '0;
                    if (r_final) begin
                        n_final = 1'b0;
                        n_state = S_IDLE;
                        if (r_cmd.last) begin
                            n_bw  = '0;
                            n_err = 1'b0;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_data  = r_word;
    assign o_count = r_cnt;
    assign o_last  = r_final;
    assign o_done  = r_cmd.last;
    assign o_err   = r_err || r_cmd.end_in_token;

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_left <= n_left;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bw    <= '0;
            r_err   <= 1'b0;
            r_word  <= '0;
            r_cnt   <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bw    <= n_bw;
            r_err   <= n_err;
            r_word  <= n_word;
            r_cnt   <= n_cnt;
            r_final <= n_final;
        end
    end

    a_push_only_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (r_state == S_PUSH) && !i_res_full)
        else $error("result pushed outside push state or into a full queue");

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(OUT_LANES))
        else $error("packed byte count exceeds lane count");

    a_final_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && r_final) |=> (r_state == S_IDLE))
        else $error("engine did not return to idle after last word");

    a_pop_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE) && !i_cmd_empty)
        else $error("command taken while engine busy");
endmodule

### sv/yaz0_stream_decompressor.sv
// Top level of the Yaz0 stream decompressor.
//
// Usage: compressed bytes (header removed) enter on i_in_byte/i_in_last; a
// request is taken at a clock edge with push high and full low. Decoded bytes
// leave as words of up to 8 bytes on o_out_data (first byte in lane 0) with
// o_out_count valid lanes; the oldest word waits while empty is low and is
// taken when pop is high. o_out_last marks the final word caused by one input
// byte, o_stream_done marks words of the byte that carried in_last, and
// o_error_flag reports a reference before the stream start or a stream that
// ended inside a token. Write i_cfg_wdata with i_cfg_we to set the number of
// bytes expected; output past it is dropped, only while the block is idle.
// The parser takes one byte per cycle into a 4-entry command queue while that
// queue is not full; the copy engine takes a command in its idle state, writes
// a literal byte straight into the window, reads the window and then writes
// for each copied byte, and pushes each result word once the result queue has
// room, so it does not take a new command before the last one is through.
// Reset clears all control state but the engine's held command and its
// remaining length; the history window is left unset. When the receiver
// stalls, the 2-entry result queue fills, the engine holds, the command
// queue fills and full rises.
module yaz0_stream_decompressor import yzd_pkg::*; #(
    parameter int unsigned WINDOW_DEPTH = DefWindowDepth,
    parameter int unsigned OUT_LANES    = DefOutLanes
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_in_last,
    input  logic                           pop,
    output logic                           empty,
    output logic [8*OUT_LANES-1:0]         o_out_data,
    output logic [$clog2(OUT_LANES+1)-1:0] o_out_count,
    output logic                           o_out_last,
    output logic                           o_stream_done,
    output logic                           o_error_flag,
    input  logic                           i_cfg_we,
    input  logic [31:0]                    i_cfg_wdata
);
    localparam int unsigned CW   = $clog2(OUT_LANES + 1);
    localparam int unsigned DW   = 8 * OUT_LANES;
    localparam int unsigned ResW = DW + CW + 3;

    logic [31:0] r_limit;

    logic cmd_valid, cmd_full, cmd_empty, cmd_pop;
    t_cmd front_cmd, back_cmd;
    logic [CmdW-1:0] cmd_rd;

    logic            res_push, res_full, res_empty;
    logic [DW-1:0]   b_data;
    logic [CW-1:0]   b_count;
    logic            b_last, b_done, b_err;
    logic [ResW-1:0] res_rd;

    // hold the byte limit; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    assign full = cmd_full;

    yzd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push && !cmd_full),
        .i_byte     (i_in_byte),
        .i_last     (i_in_last),
        .i_limit    (r_limit),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (front_cmd)
    );

    yzd_fifo #(.WIDTH(CmdW), .DEPTH(4)) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_valid),
        .i_data (front_cmd),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (cmd_rd),
        .o_empty(cmd_empty)
    );

    assign back_cmd = t_cmd'(cmd_rd);

    yzd_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .OUT_LANES(OUT_LANES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_empty(cmd_empty),
        .i_cmd      (back_cmd),
        .o_cmd_pop  (cmd_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_data     (b_data),
        .o_count    (b_count),
        .o_last     (b_last),
        .o_done     (b_done),
        .o_err      (b_err)
    );

    yzd_fifo #(.WIDTH(ResW), .DEPTH(2)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data ({b_data, b_count, b_last, b_done, b_err}),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_rd),
        .o_empty(res_empty)
    );

    assign empty = res_empty;
    assign {o_out_data, o_out_count, o_out_last, o_stream_done, o_error_flag} = res_rd;
endmodule
